@@ hw/rtl/mave_pkg.sv @@
// Package with shared widths, command types and the microcode table of the mesh statistics block.
package mave_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int FIELD_W     = 16;
    localparam int EW          = COORD_WIDTH + 1;   // edge component width
    localparam int NW          = 2 * EW;            // normal component width
    localparam int PW          = 2 * NW;            // product width
    localparam int AW          = 2 * NW + 2;        // accumulator and radicand width
    localparam int RTW         = NW + 1;            // square root width
    localparam int RMW         = NW + 3;            // square root remainder width
    localparam int SQCW        = $clog2(RTW + 1);
    localparam int SHORT_SHIFT = AW - 2 * EW;
    localparam int AREA_W      = 57;
    localparam int VOL_W       = 63;
    localparam int EDGE_W      = 18;
    localparam int CNT_W       = 32;
    localparam int OAREA_W     = 56;
    localparam int OVOL_W      = 61;
    localparam int DV_W        = 64;
    localparam int DV_STEPS    = DV_W / 4;
    localparam int DVCW        = $clog2(DV_STEPS + 1);
    localparam int PCW         = 5;

    localparam logic [PCW-1:0] PC_AREA = 5'd0;
    localparam logic [PCW-1:0] PC_EDGE = 5'd15;
    localparam logic [PCW-1:0] PC_END  = 5'd27;

    localparam logic REG_AREA_VOLUME = 1'b0;
    localparam logic REG_EDGE_LENGTH = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE, S_RUN, S_SQRT, S_DIVGO, S_DIV, S_OUT
    } t_state;

    typedef enum logic [3:0] {
        SRC_ABX, SRC_ABY, SRC_ABZ, SRC_ACX, SRC_ACY, SRC_ACZ,
        SRC_BCX, SRC_BCY, SRC_BCZ, SRC_AX, SRC_AY, SRC_AZ,
        SRC_NX, SRC_NY, SRC_NZ
    } t_src;

    typedef enum logic [2:0] {
        DST_NONE, DST_NX, DST_NY, DST_NZ, DST_VOL
    } t_dst;

    typedef struct packed {
        logic load;
        logic mul_en;
        t_src sel_a;
        t_src sel_b;
        logic neg;
        logic clr;
        t_dst dst;
        logic sqrt_go;
        logic sqrt_long;
        logic div_go;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic sqrt_busy;
        logic div_busy;
    } t_sts;

    localparam t_cmd CMD_NOP = '{load: 1'b0, mul_en: 1'b0, sel_a: SRC_ABX, sel_b: SRC_ABX,
                                 neg: 1'b0, clr: 1'b0, dst: DST_NONE, sqrt_go: 1'b0,
                                 sqrt_long: 1'b0, div_go: 1'b0, out_load: 1'b0};

    function automatic t_cmd cmd_mul(t_src a, t_src b, logic neg, logic clr, t_dst dst);
        t_cmd c;
        c        = CMD_NOP;
        c.mul_en = 1'b1;
        c.sel_a  = a;
        c.sel_b  = b;
        c.neg    = neg;
        c.clr    = clr;
        c.dst    = dst;
        return c;
    endfunction

    function automatic t_cmd cmd_sqrt(logic is_long);
        t_cmd c;
        c           = CMD_NOP;
        c.sqrt_go   = 1'b1;
        c.sqrt_long = is_long;
        return c;
    endfunction

    function automatic t_cmd cmd_store(t_dst dst);
        t_cmd c;
        c     = CMD_NOP;
        c.dst = dst;
        return c;
    endfunction

    // Microcode: cross product, volume dot product, area norm, then the norms of edges AB, AC and BC.
    function automatic t_cmd ucode(logic [PCW-1:0] pc);
        t_cmd c;
        unique case (pc)
            5'd0:    c = cmd_mul(SRC_ABY, SRC_ACZ, 1'b0, 1'b1, DST_NONE);
            5'd1:    c = cmd_mul(SRC_ABZ, SRC_ACY, 1'b1, 1'b0, DST_NONE);
            5'd2:    c = cmd_mul(SRC_ABZ, SRC_ACX, 1'b0, 1'b1, DST_NX);
            5'd3:    c = cmd_mul(SRC_ABX, SRC_ACZ, 1'b1, 1'b0, DST_NONE);
            5'd4:    c = cmd_mul(SRC_ABX, SRC_ACY, 1'b0, 1'b1, DST_NY);
            5'd5:    c = cmd_mul(SRC_ABY, SRC_ACX, 1'b1, 1'b0, DST_NONE);
            5'd6:    c = cmd_store(DST_NZ);
            5'd7:    c = cmd_mul(SRC_AX, SRC_NX, 1'b0, 1'b1, DST_NONE);
            5'd8:    c = cmd_mul(SRC_AY, SRC_NY, 1'b0, 1'b0, DST_NONE);
            5'd9:    c = cmd_mul(SRC_AZ, SRC_NZ, 1'b0, 1'b0, DST_NONE);
            5'd10:   c = cmd_store(DST_VOL);
            5'd11:   c = cmd_mul(SRC_NX, SRC_NX, 1'b0, 1'b1, DST_NONE);
            5'd12:   c = cmd_mul(SRC_NY, SRC_NY, 1'b0, 1'b0, DST_NONE);
            5'd13:   c = cmd_mul(SRC_NZ, SRC_NZ, 1'b0, 1'b0, DST_NONE);
            5'd14:   c = cmd_sqrt(1'b1);
            5'd15:   c = cmd_mul(SRC_ABX, SRC_ABX, 1'b0, 1'b1, DST_NONE);
            5'd16:   c = cmd_mul(SRC_ABY, SRC_ABY, 1'b0, 1'b0, DST_NONE);
            5'd17:   c = cmd_mul(SRC_ABZ, SRC_ABZ, 1'b0, 1'b0, DST_NONE);
            5'd18:   c = cmd_sqrt(1'b0);
            5'd19:   c = cmd_mul(SRC_ACX, SRC_ACX, 1'b0, 1'b1, DST_NONE);
            5'd20:   c = cmd_mul(SRC_ACY, SRC_ACY, 1'b0, 1'b0, DST_NONE);
            5'd21:   c = cmd_mul(SRC_ACZ, SRC_ACZ, 1'b0, 1'b0, DST_NONE);
            5'd22:   c = cmd_sqrt(1'b0);
            5'd23:   c = cmd_mul(SRC_BCX, SRC_BCX, 1'b0, 1'b1, DST_NONE);
            5'd24:   c = cmd_mul(SRC_BCY, SRC_BCY, 1'b0, 1'b0, DST_NONE);
            5'd25:   c = cmd_mul(SRC_BCZ, SRC_BCZ, 1'b0, 1'b0, DST_NONE);
            5'd26:   c = cmd_sqrt(1'b0);
            default: c = CMD_NOP;
        endcase
        return c;
    endfunction

    // One radix-16 digit of a division by six: returns {quotient digit, remainder}.
    function automatic logic [6:0] div6_digit(logic [6:0] idx);
        logic [3:0] q;
        logic [6:0] r;
        q = '0;
        for (int k = 1; k < 16; k++) begin
            if (idx >= 7'(6 * k)) q = 4'(k);
        end
        r = idx - 7'(6 * q);
        return {q, r[2:0]};
    endfunction

endpackage

@@ hw/rtl/mave_ctrl.sv @@
// Controller of the mesh statistics block: handshakes, configuration and microcode sequencing.
module mave_ctrl
    import mave_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    output logic o_valid,
    input  logic i_stall,
    input  logic i_cfg_we,
    input  logic i_cfg_index,
    input  logic i_cfg_data,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state         r_state, n_state;
    logic [PCW-1:0] r_pc, n_pc;
    logic           r_out_valid, n_out_valid;
    logic           r_area_en, r_edge_en;
    logic           w_accept;
    t_cmd           w_ucmd;

    assign w_accept = i_valid && (r_state == S_IDLE);
    assign o_stall  = (r_state != S_IDLE);
    assign o_valid  = r_out_valid;
    assign w_ucmd   = ucode(r_pc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pc        <= '0;
            r_out_valid <= 1'b0;
            r_area_en   <= 1'b1;
            r_edge_en   <= 1'b1;
        end else begin
            r_state     <= n_state;
            r_pc        <= n_pc;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_AREA_VOLUME: r_area_en <= i_cfg_data;
                    REG_EDGE_LENGTH: r_edge_en <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        n_state = r_state;
        n_pc    = r_pc;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (r_area_en) begin
                        n_state = S_RUN;
                        n_pc    = PC_AREA;
                    end else if (r_edge_en) begin
                        n_state = S_RUN;
                        n_pc    = PC_EDGE;
                    end else begin
                        n_state = S_DIVGO;
                    end
                end
            end
            S_RUN: begin
                n_pc = r_pc + 1'b1;
                if (w_ucmd.sqrt_go) n_state = S_SQRT;
            end
            S_SQRT: begin
                if (!i_sts.sqrt_busy) begin
                    if (r_pc == PC_END || (r_pc == PC_EDGE && !r_edge_en)) n_state = S_DIVGO;
                    else n_state = S_RUN;
                end
            end
            S_DIVGO: n_state = S_DIV;
            S_DIV: begin
                if (!i_sts.div_busy) n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || !i_stall) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = CMD_NOP;
        n_out_valid = r_out_valid && i_stall;
        unique case (r_state)
            S_IDLE:  o_cmd.load = w_accept;
            S_RUN:   o_cmd = w_ucmd;
            S_DIVGO: o_cmd.div_go = 1'b1;
            S_OUT: begin
                if (!r_out_valid || !i_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                end
            end
            default: o_cmd = CMD_NOP;
        endcase
    end

endmodule

@@ hw/rtl/mave_dp.sv @@
// Datapath of the mesh statistics block: shared multiplier, square root, divider and totals.
module mave_dp
    import mave_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    output t_sts                     o_sts,
    input  logic                     i_start_req,
    input  logic signed [FIELD_W-1:0] i_ax,
    input  logic signed [FIELD_W-1:0] i_ay,
    input  logic signed [FIELD_W-1:0] i_az,
    input  logic signed [FIELD_W-1:0] i_bx,
    input  logic signed [FIELD_W-1:0] i_by_coord,
    input  logic signed [FIELD_W-1:0] i_bz,
    input  logic signed [FIELD_W-1:0] i_cx,
    input  logic signed [FIELD_W-1:0] i_cy,
    input  logic signed [FIELD_W-1:0] i_cz,
    output logic [CNT_W-1:0]         o_triangle_count,
    output logic [OAREA_W-1:0]       o_total_area,
    output logic signed [OVOL_W-1:0] o_total_volume,
    output logic [EDGE_W-1:0]        o_min_edge,
    output logic [EDGE_W-1:0]        o_max_edge
);

    logic signed [COORD_WIDTH-1:0] w_a [3];
    logic signed [COORD_WIDTH-1:0] w_b [3];
    logic signed [COORD_WIDTH-1:0] w_c [3];

    logic signed [COORD_WIDTH-1:0] r_a [3];
    logic signed [EW-1:0]          r_e [9];
    logic signed [NW-1:0]          r_n [3];
    logic signed [PW-1:0]          r_p;
    logic                          r_p_vld, r_p_neg, r_p_clr;
    logic signed [AW-1:0]          r_acc, n_acc, w_base, w_pext;
    logic signed [NW-1:0]          w_opa, w_opb;

    logic [AW-1:0]   r_rad;
    logic [RMW-1:0]  r_rem, n_rem;
    logic [RTW-1:0]  r_root, n_root;
    logic [SQCW-1:0] r_sq_cnt;
    logic            r_sq_busy, r_sq_area, w_sq_last;
    logic [RMW+1:0]  w_sq_t, w_sq_trial;
    logic [EDGE_W-1:0] w_elen;

    logic [AREA_W-1:0]       r_area;
    logic signed [VOL_W-1:0] r_vol;
    logic [EDGE_W-1:0]       r_short, r_long;
    logic [CNT_W-1:0]        r_count;
    logic [AREA_W:0]         w_area_sum;
    logic signed [AW:0]      w_vol_sum;

    logic [DV_W-1:0]  r_dv_mag, r_dv_q;
    logic [2:0]       r_dv_rem;
    logic [DVCW-1:0]  r_dv_cnt;
    logic             r_dv_busy, r_dv_neg;
    logic [6:0]       w_dv_dig;
    logic [OVOL_W-1:0] w_quot;

    localparam logic signed [AW:0] VOL_HI = (AW + 1)'((64'sd1 <<< (VOL_W - 1)) - 1);
    localparam logic signed [AW:0] VOL_LO = -((AW + 1)'(64'sd1 <<< (VOL_W - 1)));

    assign w_a = '{i_ax, i_ay, i_az};
    assign w_b = '{i_bx, i_by_coord, i_bz};
    assign w_c = '{i_cx, i_cy, i_cz};

    function automatic logic signed [NW-1:0] pick(t_src s, logic signed [EW-1:0] e [9],
                                                  logic signed [COORD_WIDTH-1:0] a [3],
                                                  logic signed [NW-1:0] n [3]);
        logic signed [NW-1:0] v;
        unique case (s)
            SRC_ABX: v = NW'(e[0]);
            SRC_ABY: v = NW'(e[1]);
            SRC_ABZ: v = NW'(e[2]);
            SRC_ACX: v = NW'(e[3]);
            SRC_ACY: v = NW'(e[4]);
            SRC_ACZ: v = NW'(e[5]);
            SRC_BCX: v = NW'(e[6]);
            SRC_BCY: v = NW'(e[7]);
            SRC_BCZ: v = NW'(e[8]);
            SRC_AX:  v = NW'(a[0]);
            SRC_AY:  v = NW'(a[1]);
            SRC_AZ:  v = NW'(a[2]);
            SRC_NX:  v = n[0];
            SRC_NY:  v = n[1];
            SRC_NZ:  v = n[2];
            default: v = '0;
        endcase
        return v;
    endfunction

    assign w_opa  = pick(i_cmd.sel_a, r_e, r_a, r_n);
    assign w_opb  = pick(i_cmd.sel_b, r_e, r_a, r_n);
    assign w_base = r_p_clr ? '0 : r_acc;
    assign w_pext = r_p_neg ? -AW'(r_p) : AW'(r_p);
    assign n_acc  = r_p_vld ? w_base + w_pext : r_acc;

    // Restoring square root, one result bit per cycle.
    assign w_sq_t     = {r_rem, r_rad[AW-1 -: 2]};
    assign w_sq_trial = (RMW + 2)'({r_root, 2'b01});
    assign w_sq_last  = (r_sq_cnt == SQCW'(1));
    always_comb begin
        if (w_sq_t >= w_sq_trial) begin
            n_rem  = RMW'(w_sq_t - w_sq_trial);
            n_root = {r_root[RTW-2:0], 1'b1};
        end else begin
            n_rem  = RMW'(w_sq_t);
            n_root = {r_root[RTW-2:0], 1'b0};
        end
    end
    assign w_elen     = (|n_root[RTW-1:EDGE_W]) ? '1 : n_root[EDGE_W-1:0];
    assign w_area_sum = (AREA_W + 1)'(r_area) + (AREA_W + 1)'(n_root);
    assign w_vol_sum  = (AW + 1)'(r_vol) + (AW + 1)'(n_acc);

    assign w_dv_dig = div6_digit({r_dv_rem, r_dv_mag[DV_W-1 -: 4]});
    assign w_quot   = r_dv_neg ? -r_dv_q[OVOL_W-1:0] : r_dv_q[OVOL_W-1:0];

    assign o_sts.sqrt_busy = r_sq_busy;
    assign o_sts.div_busy  = r_dv_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld   <= 1'b0;
            r_sq_busy <= 1'b0;
            r_dv_busy <= 1'b0;
            r_area    <= '0;
            r_vol     <= '0;
            r_short   <= '1;
            r_long    <= '0;
            r_count   <= '0;
        end else begin
            r_p_vld <= i_cmd.mul_en;
            r_p_neg <= i_cmd.neg;
            r_p_clr <= i_cmd.clr;
            r_p     <= w_opa * w_opb;
            r_acc   <= n_acc;

            if (i_cmd.load) begin
                for (int i = 0; i < 3; i++) begin
                    r_a[i]   <= w_a[i];
                    r_e[i]   <= EW'(w_b[i]) - EW'(w_a[i]);
                    r_e[i+3] <= EW'(w_c[i]) - EW'(w_a[i]);
                    r_e[i+6] <= EW'(w_c[i]) - EW'(w_b[i]);
                end
                if (i_start_req) begin
                    r_area  <= '0;
                    r_vol   <= '0;
                    r_short <= '1;
                    r_long  <= '0;
                    r_count <= CNT_W'(1);
                end else if (r_count != '1) begin
                    r_count <= r_count + 1'b1;
                end
            end

            unique case (i_cmd.dst)
                DST_NX:  r_n[0] <= NW'(n_acc);
                DST_NY:  r_n[1] <= NW'(n_acc);
                DST_NZ:  r_n[2] <= NW'(n_acc);
                DST_VOL: begin
                    if (w_vol_sum > VOL_HI)      r_vol <= VOL_W'(VOL_HI);
                    else if (w_vol_sum < VOL_LO) r_vol <= VOL_W'(VOL_LO);
                    else                         r_vol <= VOL_W'(w_vol_sum);
                end
                default: ;
            endcase

            if (i_cmd.sqrt_go) begin
                r_sq_busy <= 1'b1;
                r_sq_area <= i_cmd.sqrt_long;
                r_rem     <= '0;
                r_root    <= '0;
                if (i_cmd.sqrt_long) begin
                    r_rad    <= AW'(n_acc);
                    r_sq_cnt <= SQCW'(RTW);
                end else begin
                    r_rad    <= {n_acc[2*EW-1:0], {SHORT_SHIFT{1'b0}}};
                    r_sq_cnt <= SQCW'(EW);
                end
            end else if (r_sq_busy) begin
                r_rem    <= n_rem;
                r_root   <= n_root;
                r_rad    <= {r_rad[AW-3:0], 2'b00};
                r_sq_cnt <= r_sq_cnt - 1'b1;
                if (w_sq_last) begin
                    r_sq_busy <= 1'b0;
                    if (r_sq_area) begin
                        r_area <= w_area_sum[AREA_W] ? '1 : w_area_sum[AREA_W-1:0];
                    end else begin
                        if (w_elen < r_short) r_short <= w_elen;
                        if (w_elen > r_long)  r_long  <= w_elen;
                    end
                end
            end

            if (i_cmd.div_go) begin
                r_dv_busy <= 1'b1;
                r_dv_neg  <= r_vol[VOL_W-1];
                r_dv_mag  <= r_vol[VOL_W-1] ? -DV_W'(r_vol) : DV_W'(r_vol);
                r_dv_q    <= '0;
                r_dv_rem  <= '0;
                r_dv_cnt  <= DVCW'(DV_STEPS);
            end else if (r_dv_busy) begin
                r_dv_mag <= {r_dv_mag[DV_W-5:0], 4'b0000};
                r_dv_q   <= {r_dv_q[DV_W-5:0], w_dv_dig[6:3]};
                r_dv_rem <= w_dv_dig[2:0];
                r_dv_cnt <= r_dv_cnt - 1'b1;
                if (r_dv_cnt == DVCW'(1)) r_dv_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_triangle_count <= r_count;
            o_total_area     <= r_area[AREA_W-1:1];
            o_total_volume   <= w_quot;
            o_min_edge       <= r_short;
            o_max_edge       <= r_long;
        end
    end

endmodule

@@ hw/rtl/mesh_area_volume_edge_stats.sv @@
// Top level of the triangle mesh area, signed volume and edge length statistics block.
//
// One input word carries one triangle (three signed Q8.8 vertices) and a start flag
// that clears the running totals before the triangle is counted. Every input word
// produces exactly one output word with the running count, area (Q40.16), signed
// volume divided by six (Q.24) and the shortest and longest edge (Q.8).
// Both channels use valid and stall; a word moves on a clock edge with valid high
// and stall low. o_stall is high while a triangle is in work, so one triangle is
// processed at a time.
// A new triangle is taken only after the one before it has reached the output load.
// With both features on, the work is 15 microcode steps on the single shared
// multiplier for the cross product, volume and area norm, a 35-step area square root
// plus a handoff, the norms of edges AB, AC and BC with their square roots, a dispatch
// step, a 16-step radix-16 divide by six plus a handoff, and the output load. With
// area off the 15 steps and area root are skipped; with edges off, the edge norms.
// The result sits in an output register; if the receiver stalls, it holds and the
// next triangle is accepted but waits at its end until the register is free.
// Synchronous active-low reset clears the totals, empties the output register and
// sets both enables. Configuration writes take effect at once.
module mesh_area_volume_edge_stats
    import mave_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic                      i_start_req,
    input  logic signed [FIELD_W-1:0] i_ax,
    input  logic signed [FIELD_W-1:0] i_ay,
    input  logic signed [FIELD_W-1:0] i_az,
    input  logic signed [FIELD_W-1:0] i_bx,
    input  logic signed [FIELD_W-1:0] i_by_coord,
    input  logic signed [FIELD_W-1:0] i_bz,
    input  logic signed [FIELD_W-1:0] i_cx,
    input  logic signed [FIELD_W-1:0] i_cy,
    input  logic signed [FIELD_W-1:0] i_cz,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [CNT_W-1:0]          o_triangle_count,
    output logic [OAREA_W-1:0]        o_total_area,
    output logic signed [OVOL_W-1:0]  o_total_volume,
    output logic [EDGE_W-1:0]         o_min_edge,
    output logic [EDGE_W-1:0]         o_max_edge,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_index,
    input  logic                      i_cfg_data
);

    // Commands flow from the sequencer to the datapath, busy flags flow back.
    t_cmd w_cmd;
    t_sts w_sts;

    mave_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    mave_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_start_req      (i_start_req),
        .i_ax             (i_ax),
        .i_ay             (i_ay),
        .i_az             (i_az),
        .i_bx             (i_bx),
        .i_by_coord       (i_by_coord),
        .i_bz             (i_bz),
        .i_cx             (i_cx),
        .i_cy             (i_cy),
        .i_cz             (i_cz),
        .o_triangle_count (o_triangle_count),
        .o_total_area     (o_total_area),
        .o_total_volume   (o_total_volume),
        .o_min_edge       (o_min_edge),
        .o_max_edge       (o_max_edge)
    );

endmodule

@@ hw/rtl/mave_chk.sv @@
// Port-level checker for the mesh statistics block, bound to the top level.
module mave_chk
    import mave_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_stall,
    input logic              o_valid,
    input logic              i_stall,
    input logic [CNT_W-1:0]  o_triangle_count
);

    // Reset empties the output register and opens the input.
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid && !o_stall)
        else $error("outputs not cleared by reset");

    // Once a triangle is taken the block is busy on the next cycle.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("second word taken while busy");

    // A stalled output word stays presented.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_triangle_count))
        else $error("stalled output word dropped or changed");

    // No triangle can finish in the cycle right after it was accepted.
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && !o_valid |=> !o_valid)
        else $error("result appeared too early");

endmodule

bind mesh_area_volume_edge_stats mave_chk u_mave_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_valid          (i_valid),
    .o_stall          (o_stall),
    .o_valid          (o_valid),
    .i_stall          (i_stall),
    .o_triangle_count (o_triangle_count)
);
